// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Used by the screen memory and the top level; depends on nothing.
package tcw_pkg;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] code;
	} cell_t;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_ERASE = 2'd2;

	localparam logic [0:0] REG_TEXT_ATTR  = 1'd0;
	localparam logic [0:0] REG_BLANK_ATTR = 1'd1;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h1E;

endpackage

// File: rtl/tcw_screen_ram.sv
// Screen cell memory: one write port and one read port, read data registered.
// Depends on tcw_pkg for the cell type.
module tcw_screen_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  tcw_pkg::cell_t     wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output tcw_pkg::cell_t     rdata
);

	tcw_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/text_console_writer.sv
// Top level of the text console writer: command sequencer, cursor and the
// circular row map over the screen memory. Depends on tcw_pkg, tcw_screen_ram.
//
// Channel   Direction  Handshake                Beat
// command   in         start && !busy           command, char_code, read_row, read_column
// result    out        done, one cycle          cursor_row, cursor_column, cell_data
// config    in         cfg_write                cfg_index, cfg_data
//
// A put, an unused code or a read outside the screen passes through CALC and EXEC
// from accept to the next accept; a read inside the screen also passes through
// RDWAIT, as the memory read port returns registered data.
// A scroll adds a FILL pass blanking one row of the memory and a clear adds a
// FILL pass over every cell of the memory, one cell per cycle.
// After reset busy stays high while the memory is filled with blank cells.
// Results cannot be stalled by the receiver.
module text_console_writer #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_LINES   = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  char_code,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_column,
	output logic        done,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column,
	output logic [15:0] cell_data,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CELLS = SCREEN_LINES * SCREEN_COLUMNS;
	localparam int RW    = $clog2(SCREEN_LINES);
	localparam int CW    = $clog2(SCREEN_COLUMNS);
	localparam int AW    = $clog2(CELLS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CALC   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_RDWAIT = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;

	logic [2:0]     state_q;
	logic [7:0]     text_attr_q;
	logic [7:0]     blank_attr_q;
	logic [RW-1:0]  cur_row_q;
	logic [CW-1:0]  cur_col_q;
	logic [RW-1:0]  top_q;
	logic [1:0]     cmd_q;
	logic [7:0]     char_q;
	logic [4:0]     rrow_q;
	logic [6:0]     rcol_q;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  base_q;
	logic           rd_ok_q;
	logic [AW-1:0]  fill_addr_q;
	logic [AW-1:0]  fill_last_q;
	tcw_pkg::cell_t fill_cell_q;
	logic           fill_scroll_q;
	logic           fill_reset_q;
	logic           done_q;
	tcw_pkg::cell_t cell_q;

	logic [RW-1:0]  log_row;
	logic [CW-1:0]  log_col;
	logic [RW:0]    phys_sum;
	logic [RW-1:0]  phys_row;
	logic [31:0]    rrow_ext;
	logic [31:0]    rcol_ext;
	logic [31:0]    row_ext;
	logic [31:0]    col_ext;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	tcw_pkg::cell_t mem_wdata;
	logic           mem_re;
	tcw_pkg::cell_t mem_rdata;

	logic           is_bs;
	logic           is_nl;

	assign rrow_ext = 32'(rrow_q);
	assign rcol_ext = 32'(rcol_q);
	assign is_bs    = (char_q == tcw_pkg::CH_BACKSPACE);
	assign is_nl    = (char_q == tcw_pkg::CH_NEWLINE);

	always_comb begin
		if (cmd_q == tcw_pkg::CMD_READ) begin
			log_row = rrow_ext[RW-1:0];
			log_col = rcol_ext[CW-1:0];
		end else begin
			log_row = cur_row_q;
			log_col = is_bs ? (cur_col_q - CW'(1)) : cur_col_q;
		end
		phys_sum = {1'b0, log_row} + {1'b0, top_q};
		if (32'(phys_sum) >= SCREEN_LINES) begin
			phys_row = RW'(32'(phys_sum) - SCREEN_LINES);
		end else begin
			phys_row = phys_sum[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q  <= tcw_pkg::ATTR_RESET;
			blank_attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tcw_pkg::REG_TEXT_ATTR:  text_attr_q  <= cfg_data;
				tcw_pkg::REG_BLANK_ATTR: blank_attr_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_FILL;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			top_q         <= '0;
			fill_addr_q   <= '0;
			fill_last_q   <= AW'(CELLS - 1);
			fill_cell_q   <= '{attr: tcw_pkg::ATTR_RESET, code: tcw_pkg::CH_SPACE};
			fill_scroll_q <= 1'b0;
			fill_reset_q  <= 1'b1;
			done_q        <= 1'b0;
			cmd_q         <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						char_q  <= char_code;
						rrow_q  <= read_row;
						rcol_q  <= read_column;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					addr_q  <= AW'(32'(phys_row) * SCREEN_COLUMNS + 32'(log_col));
					base_q  <= AW'(32'(top_q) * SCREEN_COLUMNS);
					rd_ok_q <= (rrow_ext < SCREEN_LINES) && (rcol_ext < SCREEN_COLUMNS);
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					cell_q  <= '0;
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					case (cmd_q)
						tcw_pkg::CMD_PUT: begin
							if (is_bs) begin
								if (cur_col_q != '0) begin
									cur_col_q <= cur_col_q - CW'(1);
								end
							end else if (is_nl ||
									cur_col_q == CW'(SCREEN_COLUMNS - 1)) begin
								cur_col_q <= '0;
								if (cur_row_q == RW'(SCREEN_LINES - 1)) begin
									fill_addr_q   <= base_q;
									fill_last_q   <= base_q + AW'(SCREEN_COLUMNS - 1);
									fill_cell_q   <= '{attr: blank_attr_q,
										code: tcw_pkg::CH_SPACE};
									fill_scroll_q <= 1'b1;
									fill_reset_q  <= 1'b0;
									state_q       <= ST_FILL;
									done_q        <= 1'b0;
								end else begin
									cur_row_q <= cur_row_q + RW'(1);
								end
							end else begin
								cur_col_q <= cur_col_q + CW'(1);
							end
						end
						tcw_pkg::CMD_READ: begin
							if (rd_ok_q) begin
								state_q <= ST_RDWAIT;
								done_q  <= 1'b0;
							end
						end
						tcw_pkg::CMD_ERASE: begin
							cur_row_q     <= '0;
							cur_col_q     <= '0;
							top_q         <= '0;
							fill_addr_q   <= '0;
							fill_last_q   <= AW'(CELLS - 1);
							fill_cell_q   <= '{attr: blank_attr_q, code: tcw_pkg::CH_SPACE};
							fill_scroll_q <= 1'b0;
							fill_reset_q  <= 1'b0;
							state_q       <= ST_FILL;
							done_q        <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				ST_RDWAIT: begin
					cell_q  <= mem_rdata;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					fill_addr_q <= fill_addr_q + AW'(1);
					if (fill_addr_q == fill_last_q) begin
						if (fill_scroll_q) begin
							top_q <= (top_q == RW'(SCREEN_LINES - 1)) ? '0 : top_q + RW'(1);
						end
						done_q  <= !fill_reset_q;
						cell_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '{attr: text_attr_q, code: char_q};
		mem_re    = 1'b0;
		if (state_q == ST_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = fill_addr_q;
			mem_wdata = fill_cell_q;
		end else if (state_q == ST_EXEC) begin
			if (cmd_q == tcw_pkg::CMD_PUT) begin
				if (is_bs) begin
					mem_we    = (cur_col_q != '0);
					mem_wdata = '{attr: text_attr_q, code: tcw_pkg::CH_SPACE};
				end else if (!is_nl) begin
					mem_we = 1'b1;
				end
			end else if (cmd_q == tcw_pkg::CMD_READ) begin
				mem_re = rd_ok_q;
			end
		end
	end

	tcw_screen_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	assign row_ext       = 32'(cur_row_q);
	assign col_ext       = 32'(cur_col_q);
	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign cursor_row    = row_ext[4:0];
	assign cursor_column = col_ext[6:0];
	assign cell_data     = cell_q;

endmodule
